>>> hdl/act_pkg.sv
`timescale 1ns / 1ps
package act_pkg;
  localparam int unsigned Capacity = 64;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam logic [31:0] MaxAgeRst = 32'd60000;
  localparam logic [31:0] AllOnes   = 32'hFFFF_FFFF;
  localparam int unsigned EntW     = 24 + 32 + 16;

  typedef enum logic [2:0] {
    OP_FIND   = 3'd0,
    OP_ADD    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_OLDEST = 3'd3,
    OP_FAR    = 3'd4,
    OP_UPDATE = 3'd5,
    OP_READ   = 3'd6,
    OP_NONE   = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NONE   = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADIDX = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SHIFT_RD, S_SHIFT_WR, S_FETCH, S_FETCH_WAIT, S_DONE
  } state_e;
endpackage

>>> hdl/act_req_if.sv
`timescale 1ns / 1ps
interface act_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [23:0] address;
  logic [31:0] now;
  logic [5:0]  slot_index;
  logic [31:0] new_timestamp;
  logic [15:0] new_range;
  modport source (output valid, opcode, address, now, slot_index, new_timestamp,
                  new_range, input ready);
  modport sink (input valid, opcode, address, now, slot_index, new_timestamp,
                new_range, output ready);
endinterface

>>> hdl/act_rsp_if.sv
`timescale 1ns / 1ps
interface act_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  result_index;
  logic [6:0]  entry_count;
  logic [23:0] entry_address;
  logic [31:0] entry_timestamp;
  logic [15:0] entry_range;
  modport source (output valid, status, result_index, entry_count, entry_address,
                  entry_timestamp, entry_range, input ready);
  modport sink (input valid, status, result_index, entry_count, entry_address,
                entry_timestamp, entry_range, output ready);
endinterface

>>> hdl/act_ram.sv
`timescale 1ns / 1ps
module act_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> hdl/aging_contact_table_top.sv
`timescale 1ns / 1ps
// Sequencing: find/remove scan one entry per cycle; when an entry goes, the later
// entries shift down with a read and a write state each. Add/read pass through
// fetch, fetch-wait and done to the answer, update first does a read-modify-write,
// oldest/most-distant scan all entries before the fetch. One request in flight at a time.
// Reset (asynchronous, active low) empties the table and sets max_age to 60000;
// entry contents are not cleared.
module aging_contact_table_top
  import act_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  act_req_if.sink     req,
  act_rsp_if.source   rsp
);
  state_e            state_q, state_d;
  logic [31:0]       max_age_q;
  logic [CntW-1:0]   fill_q, fill_d;
  logic [CntW-1:0]   ptr_q, ptr_d;       // scan pointer
  logic [CntW-1:0]   shift_q, shift_d;   // shift pointer
  logic [2:0]        op_q;
  logic [23:0]       addr_q;
  logic [31:0]       now_q;
  logic [31:0]       nts_q;
  logic [15:0]       nrange_q;
  logic              aged_q, aged_d, found_q, found_d, got_q, got_d;
  logic [CntW-1:0]   old_q, old_d, hit_q, hit_d;
  logic [31:0]       best_q, best_d;
  logic              rd_pend_q, rd_pend_d;
  logic [CntW-1:0]   rd_idx_q, rd_idx_d;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        out_st_q, out_st_d;
  logic              out_ent_q, out_ent_d;
  logic [CntW-1:0]   out_idx_q, out_idx_d;

  logic              we;
  logic [IdxW-1:0]   waddr, raddr;
  logic [EntW-1:0]   wdata, rdata;
  logic [23:0]       r_addr;
  logic [31:0]       r_ts;
  logic [15:0]       r_rng;

  assign r_addr = rdata[EntW-1 -: 24];
  assign r_ts   = rdata[47:16];
  assign r_rng  = rdata[15:0];

  act_ram #(.Width(EntW), .Depth(Capacity)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_age_q <= MaxAgeRst;
    end else if (cfg_we_i) begin
      max_age_q <= cfg_wdata_i;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      rd_pend_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      rd_pend_q   <= rd_pend_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      op_q     <= req.opcode;
      addr_q   <= req.address;
      now_q    <= req.now;
      nts_q    <= req.new_timestamp;
      nrange_q <= req.new_range;
    end
    ptr_q     <= ptr_d;
    shift_q   <= shift_d;
    aged_q    <= aged_d;
    found_q   <= found_d;
    got_q     <= got_d;
    old_q     <= old_d;
    hit_q     <= hit_d;
    best_q    <= best_d;
    rd_idx_q  <= rd_idx_d;
    out_st_q  <= out_st_d;
    out_ent_q <= out_ent_d;
    out_idx_q <= out_idx_d;
  end

  assign req.ready = (state_q == S_IDLE) && !out_valid_q;

  // sequencer: the scan issues one RAM read per cycle, the result of the previous read
  // checked in the same cycle against the condition of the current operation
  always_comb begin
    logic            chk;
    logic [CntW-1:0] ci;
    state_d     = state_q;
    fill_d      = fill_q;
    ptr_d       = ptr_q;
    shift_d     = shift_q;
    aged_d      = aged_q;
    found_d     = found_q;
    got_d       = got_q;
    old_d       = old_q;
    hit_d       = hit_q;
    best_d      = best_q;
    rd_pend_d   = 1'b0;
    rd_idx_d    = rd_idx_q;
    out_valid_d = out_valid_q;
    out_st_d    = out_st_q;
    out_ent_d   = out_ent_q;
    out_idx_d   = out_idx_q;
    we          = 1'b0;
    waddr       = ptr_q[IdxW-1:0];
    wdata       = rdata;
    raddr       = ptr_q[IdxW-1:0];
    chk         = rd_pend_q;
    ci          = rd_idx_q;

    if (rsp.valid && rsp.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req.valid && req.ready) begin
          ptr_d   = '0;
          aged_d  = 1'b0;
          found_d = 1'b0;
          got_d   = 1'b0;
          best_d  = (op_e'(req.opcode) == OP_OLDEST) ? AllOnes : '0;
          unique case (op_e'(req.opcode))
            OP_FIND, OP_REMOVE, OP_OLDEST, OP_FAR: state_d = S_SCAN;
            OP_ADD: begin
              if (fill_q < CntW'(Capacity)) begin
                we        = 1'b1;
                waddr     = fill_q[IdxW-1:0];
                wdata     = {req.address, 48'd0};
                hit_d     = fill_q;
                fill_d    = fill_q + 1'b1;
                state_d   = S_FETCH;
              end else begin
                out_st_d  = ST_FULL;
                out_ent_d = 1'b0;
                state_d   = S_DONE;
              end
            end
            OP_UPDATE, OP_READ: begin
              if (CntW'(req.slot_index) < fill_q) begin
                hit_d   = CntW'(req.slot_index);
                state_d = S_FETCH;
                if (op_e'(req.opcode) == OP_UPDATE) begin
                  // address kept: read-modify-write in the shift states
                  state_d = S_SHIFT_RD;
                end
              end else begin
                out_st_d  = ST_BADIDX;
                out_ent_d = 1'b0;
                state_d   = S_DONE;
              end
            end
            default: begin
              out_st_d  = ST_NONE;
              out_ent_d = 1'b0;
              state_d   = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue next read while checking the previous one
        logic stop;
        stop = 1'b0;
        if (chk) begin
          unique case (op_e'(op_q))
            OP_FIND: begin
              if (r_addr == addr_q) begin
                found_d = 1'b1;
                hit_d   = ci;
                stop    = 1'b1;
              end else if ((r_ts + max_age_q) < now_q) begin
                aged_d = 1'b1;
                old_d  = ci;
              end
            end
            OP_REMOVE: begin
              if (r_addr == addr_q) begin
                found_d = 1'b1;
                old_d   = ci;
                stop    = 1'b1;
              end
            end
            OP_OLDEST: begin
              if (r_ts < best_q) begin
                best_d = r_ts;
                hit_d  = ci;
                got_d  = 1'b1;
              end
            end
            default: begin
              if (32'(r_rng) > best_q) begin
                best_d = 32'(r_rng);
                hit_d  = ci;
                got_d  = 1'b1;
              end
            end
          endcase
        end
        if (!stop && ptr_q < fill_q) begin
          rd_pend_d = 1'b1;
          rd_idx_d  = ptr_q;
          ptr_d     = ptr_q + 1'b1;
        end
        if (stop || ptr_q >= fill_q) begin
          // scan finished: decide removal
          rd_pend_d = 1'b0;
          if (op_e'(op_q) == OP_FIND && (aged_d)) begin
            shift_d = old_d;
            if (found_d && hit_d > old_d) hit_d = hit_d - 1'b1;
            state_d = S_SHIFT_RD;
          end else if (op_e'(op_q) == OP_REMOVE && found_d) begin
            shift_d = old_d;
            state_d = S_SHIFT_RD;
          end else begin
            got_d   = (op_e'(op_q) == OP_FIND) ? found_d : got_d;
            state_d = S_FETCH;
          end
        end
      end

      S_SHIFT_RD: begin
        if (op_e'(op_q) == OP_UPDATE) begin
          raddr   = hit_q[IdxW-1:0];
          state_d = S_SHIFT_WR;
        end else if (shift_q + 1'b1 < fill_q) begin
          raddr   = IdxW'(shift_q + 1'b1);
          state_d = S_SHIFT_WR;
        end else begin
          fill_d  = fill_q - 1'b1;
          got_d   = found_q;
          state_d = S_FETCH;
        end
      end

      S_SHIFT_WR: begin
        we = 1'b1;
        if (op_e'(op_q) == OP_UPDATE) begin
          waddr   = hit_q[IdxW-1:0];
          wdata   = {r_addr, nts_q, nrange_q};
          state_d = S_FETCH;
        end else begin
          waddr   = shift_q[IdxW-1:0];
          shift_d = shift_q + 1'b1;
          state_d = S_SHIFT_RD;
        end
      end

      S_FETCH: begin
        raddr   = hit_q[IdxW-1:0];
        state_d = S_FETCH_WAIT;
      end

      S_FETCH_WAIT: begin
        unique case (op_e'(op_q))
          OP_ADD, OP_UPDATE, OP_READ: begin
            out_st_d  = ST_OK;
            out_ent_d = 1'b1;
          end
          OP_REMOVE: begin
            out_st_d  = found_q ? ST_OK : ST_NONE;
            out_ent_d = 1'b0;
          end
          default: begin
            out_st_d  = got_q ? ST_OK : ST_NONE;
            out_ent_d = got_q;
          end
        endcase
        out_idx_d = hit_q;
        state_d   = S_DONE;
      end

      S_DONE: begin
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // result register: entry data sampled from the RAM at the fetch
  logic [EntW-1:0] ent_q;
  always_ff @(posedge clk_i) begin
    if (state_q == S_FETCH_WAIT) begin
      ent_q <= rdata;
    end
  end

  assign rsp.valid           = out_valid_q;
  assign rsp.status          = out_st_q;
  assign rsp.result_index    = out_ent_q ? out_idx_q[5:0] : 6'd0;
  assign rsp.entry_count     = 7'(fill_q);
  assign rsp.entry_address   = out_ent_q ? ent_q[EntW-1 -: 24] : 24'd0;
  assign rsp.entry_timestamp = out_ent_q ? ent_q[47:16] : 32'd0;
  assign rsp.entry_range     = out_ent_q ? ent_q[15:0] : 16'd0;

  // checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(Capacity)) else $error("fill count above capacity");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !req.ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp.ready) |=> out_valid_q) else $error("result dropped");
  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> (fill_q == $past(fill_q) + 1'b1 ||
     fill_q == $past(fill_q) - 1'b1)) else $error("fill count jumped");
endmodule
